// ===== sv/owrs_pkg.sv =====
// shared types and constants for the 1-wire rom search engine
// no dependencies

package owrs_pkg;

  localparam int unsigned ROM_BITS      = 64;
  localparam int unsigned CRC_DATA_BITS = 56;
  localparam int unsigned POS_W         = 7;
  localparam int unsigned IDX_W         = 6;
  localparam logic [7:0]  CRC_POLY_REFL = 8'h8C;

  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [ROM_BITS-1:0] rom_t;

  typedef enum logic [1:0] {
    REQ_RESET  = 2'd0,
    REQ_BEGIN  = 2'd1,
    REQ_PAIR   = 2'd2,
    REQ_FAULT  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED   = 3'd0,
    ST_DIRECTION  = 3'd1,
    ST_FOUND      = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_CRC_ERROR  = 3'd4,
    ST_NO_PRESENCE = 3'd5,
    ST_BUS_FAULT  = 3'd6,
    ST_OUTSIDE    = 3'd7
  } status_t;

endpackage

// ===== sv/owrs_in_if.sv =====
// request channel: valid/ready handshake carrying one bus event per beat
// depends on owrs_pkg

interface owrs_in_if;
  logic             valid;
  logic             ready;
  owrs_pkg::req_t   req_type;
  logic             presence_seen;
  logic             id_bit;
  logic             complement_bit;

  modport source (output valid, req_type, presence_seen, id_bit, complement_bit,
                  input ready);
  modport sink   (input valid, req_type, presence_seen, id_bit, complement_bit,
                  output ready);
endinterface

// ===== sv/owrs_out_if.sv =====
// result channel: valid/ready handshake carrying one search result per beat
// depends on owrs_pkg

interface owrs_out_if;
  logic              valid;
  logic              ready;
  owrs_pkg::status_t status;
  logic              direction;
  owrs_pkg::rom_t    rom_id;
  logic              last_device;

  modport source (output valid, status, direction, rom_id, last_device,
                  input ready);
  modport sink   (input valid, status, direction, rom_id, last_device,
                  output ready);
endinterface

// ===== sv/one_wire_rom_search_engine.sv =====
// 1-wire search rom engine: one bus event in, one result out per beat
// depends on owrs_pkg, owrs_in_if, owrs_out_if
//
// Takes one event per clock cycle and answers it in the next cycle from a single
// result register; a new event is accepted in every cycle while the result
// register is empty or being taken in the same cycle, so throughput is one
// event per cycle while the receiver keeps up. For each bit pair the engine
// returns the direction bit to write: the id bit where all devices agree, else
// the saved path below the last discrepancy, 1 at it and 0 above it; it runs
// a reflected crc-8 over the first 56 bits that is checked against the last
// byte at position 64. A good pass reports the rom code and a last-device flag;
// every failure but a pair outside a pass clears the search state.

module one_wire_rom_search_engine (
  input  logic        clk,
  input  logic        rst_n,
  owrs_in_if.sink     in_ch,
  owrs_out_if.source  out_ch
);
  import owrs_pkg::*;

  rom_t       saved_rom_r, saved_rom_nxt;
  pos_t       last_disc_r, last_disc_nxt;
  logic       last_dev_r, last_dev_nxt;
  rom_t       pass_rom_r, pass_rom_nxt;
  pos_t       pass_last_zero_r, pass_last_zero_nxt;
  pos_t       bit_pos_r, bit_pos_nxt;
  logic       pass_active_r, pass_active_nxt;
  logic [7:0] crc_r, crc_nxt;

  logic       out_valid_r;
  status_t    status_r, status_nxt;
  logic       dir_r, dir_nxt;
  rom_t       rom_id_r, rom_id_nxt;
  logic       last_out_r, last_out_nxt;

  logic       accept;
  pos_t       pos;
  logic [IDX_W-1:0] idx;
  logic       dir;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    saved_rom_nxt      = saved_rom_r;
    last_disc_nxt      = last_disc_r;
    last_dev_nxt       = last_dev_r;
    pass_rom_nxt       = pass_rom_r;
    pass_last_zero_nxt = pass_last_zero_r;
    bit_pos_nxt        = bit_pos_r;
    pass_active_nxt    = pass_active_r;
    crc_nxt            = crc_r;
    status_nxt         = ST_ACCEPTED;
    dir_nxt            = 1'b0;
    rom_id_nxt         = '0;
    last_out_nxt       = 1'b0;

    pos = (bit_pos_r >= pos_t'(ROM_BITS)) ? pos_t'(ROM_BITS) : bit_pos_r + pos_t'(1);
    idx = IDX_W'(pos - pos_t'(1));
    dir = 1'b0;

    unique case (in_ch.req_type)
      REQ_RESET: begin
        saved_rom_nxt   = '0;
        last_disc_nxt   = '0;
        last_dev_nxt    = 1'b0;
        pass_active_nxt = 1'b0;
        status_nxt      = ST_ACCEPTED;
      end
      REQ_FAULT: begin
        saved_rom_nxt   = '0;
        last_disc_nxt   = '0;
        last_dev_nxt    = 1'b0;
        pass_active_nxt = 1'b0;
        status_nxt      = ST_BUS_FAULT;
      end
      REQ_BEGIN: begin
        if (last_dev_r || !in_ch.presence_seen) begin
          saved_rom_nxt   = '0;
          last_disc_nxt   = '0;
          last_dev_nxt    = 1'b0;
          pass_active_nxt = 1'b0;
          status_nxt      = last_dev_r ? ST_NOT_FOUND : ST_NO_PRESENCE;
        end else begin
          pass_active_nxt    = 1'b1;
          bit_pos_nxt        = '0;
          pass_rom_nxt       = '0;
          pass_last_zero_nxt = '0;
          crc_nxt            = '0;
          status_nxt         = ST_ACCEPTED;
        end
      end
      REQ_PAIR: begin
        if (!pass_active_r) begin
          status_nxt = ST_OUTSIDE;
        end else if (in_ch.id_bit && in_ch.complement_bit) begin
          saved_rom_nxt   = '0;
          last_disc_nxt   = '0;
          last_dev_nxt    = 1'b0;
          pass_active_nxt = 1'b0;
          status_nxt      = ST_NOT_FOUND;
        end else begin
          // agreeing devices: id bit; else saved rom and last discrepancy
          if (in_ch.id_bit != in_ch.complement_bit) begin
            dir = in_ch.id_bit;
          end else begin
            if (pos < last_disc_r) begin
              dir = saved_rom_r[idx];
            end else begin
              dir = (pos == last_disc_r);
            end
            if (!dir) begin
              pass_last_zero_nxt = pos;
            end
          end
          if (dir) begin
            pass_rom_nxt[idx] = 1'b1;
          end
          if (pos <= pos_t'(CRC_DATA_BITS)) begin
            crc_nxt = {1'b0, crc_r[7:1]} ^ ((crc_r[0] ^ dir) ? CRC_POLY_REFL : 8'h00);
          end
          bit_pos_nxt = pos;
          dir_nxt     = dir;
          if (pos < pos_t'(ROM_BITS)) begin
            status_nxt = ST_DIRECTION;
          end else begin
            pass_active_nxt = 1'b0;
            if (pass_rom_nxt[ROM_BITS-1:CRC_DATA_BITS] != crc_r) begin
              saved_rom_nxt = '0;
              last_disc_nxt = '0;
              last_dev_nxt  = 1'b0;
              status_nxt    = ST_CRC_ERROR;
            end else begin
              saved_rom_nxt = pass_rom_nxt;
              last_disc_nxt = pass_last_zero_nxt;
              last_dev_nxt  = (pass_last_zero_nxt == '0);
              status_nxt    = ST_FOUND;
              rom_id_nxt    = pass_rom_nxt;
              last_out_nxt  = (pass_last_zero_nxt == '0);
            end
          end
        end
      end
      default: begin
        status_nxt = ST_OUTSIDE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      saved_rom_r      <= '0;
      last_disc_r      <= '0;
      last_dev_r       <= 1'b0;
      pass_rom_r       <= '0;
      pass_last_zero_r <= '0;
      bit_pos_r        <= '0;
      pass_active_r    <= 1'b0;
      crc_r            <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (accept) begin
        saved_rom_r      <= saved_rom_nxt;
        last_disc_r      <= last_disc_nxt;
        last_dev_r       <= last_dev_nxt;
        pass_rom_r       <= pass_rom_nxt;
        pass_last_zero_r <= pass_last_zero_nxt;
        bit_pos_r        <= bit_pos_nxt;
        pass_active_r    <= pass_active_nxt;
        crc_r            <= crc_nxt;
        out_valid_r      <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r      <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted beat
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r   <= status_nxt;
      dir_r      <= dir_nxt;
      rom_id_r   <= rom_id_nxt;
      last_out_r <= last_out_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.direction   = dir_r;
  assign out_ch.rom_id      = rom_id_r;
  assign out_ch.last_device = last_out_r;

endmodule

// ===== bench/tb_one_wire_rom_search_engine.sv =====
// testbench for the 1-wire search rom engine: directed and random bus event streams
// checked beat by beat against an in-bench search predictor
// depends on owrs_pkg, owrs_in_if, owrs_out_if and one_wire_rom_search_engine

module tb_one_wire_rom_search_engine;
  import owrs_pkg::*;

  localparam int unsigned CLK_PERIOD       = 12;
  localparam int unsigned RUN_LIMIT_CYCLES = 600000;
  localparam int unsigned MAX_DEVICES      = 4;

  typedef struct packed {
    status_t status;
    logic    direction;
    rom_t    rom_id;
    logic    last_device;
  } search_result_t;

  logic clk;
  logic rst_n;

  owrs_in_if  in_ch ();
  owrs_out_if out_ch ();

  one_wire_rom_search_engine uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predictor state
  rom_t       saved_path;
  pos_t       last_disc;
  logic       last_dev_flag;
  rom_t       pass_path;
  pos_t       pass_zero;
  pos_t       bit_pos;
  logic       in_pass;
  logic [7:0] crc_acc;

  search_result_t expected_results[$];
  int mismatch_count = 0;
  int events_sent;
  int burst_left;
  int stall_mode = 0;
  int stall_mode_left = 0;

  rom_t bus_devices[MAX_DEVICES];
  int   n_devices;

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic [7:0] crc_step(logic [7:0] crc, logic data_bit);
    logic mix;
    mix = crc[0] ^ data_bit;
    crc = crc >> 1;
    if (mix) crc = crc ^ CRC_POLY_REFL;
    return crc;
  endfunction

  function automatic void clear_search();
    saved_path    = '0;
    last_disc     = '0;
    last_dev_flag = 1'b0;
    in_pass       = 1'b0;
  endfunction

  function automatic search_result_t predict_search_step(req_t req, logic pres, logic idb,
                                                         logic cmp);
    search_result_t res;
    int   pos;
    logic dir;
    res = '0;
    case (req)
      REQ_RESET: begin
        clear_search();
        res.status = ST_ACCEPTED;
      end
      REQ_FAULT: begin
        clear_search();
        res.status = ST_BUS_FAULT;
      end
      REQ_BEGIN: begin
        if (last_dev_flag) begin
          clear_search();
          res.status = ST_NOT_FOUND;
        end else if (!pres) begin
          clear_search();
          res.status = ST_NO_PRESENCE;
        end else begin
          in_pass   = 1'b1;
          bit_pos   = '0;
          pass_path = '0;
          pass_zero = '0;
          crc_acc   = '0;
          res.status = ST_ACCEPTED;
        end
      end
      default: begin
        if (!in_pass) begin
          res.status = ST_OUTSIDE;
        end else begin
          pos = int'(bit_pos) + 1;
          if (pos > ROM_BITS) pos = ROM_BITS;
          if (idb && cmp) begin
            clear_search();
            res.status = ST_NOT_FOUND;
          end else begin
            if (idb != cmp) begin
              dir = idb;
            end else begin
              if (pos < int'(last_disc)) dir = saved_path[pos-1];
              else dir = (pos == int'(last_disc));
              if (!dir) pass_zero = pos_t'(pos);
            end
            if (dir) pass_path[pos-1] = 1'b1;
            if (pos <= CRC_DATA_BITS) crc_acc = crc_step(crc_acc, dir);
            bit_pos = pos_t'(pos);
            res.direction = dir;
            if (pos < ROM_BITS) begin
              res.status = ST_DIRECTION;
            end else begin
              in_pass = 1'b0;
              if (pass_path[ROM_BITS-1:CRC_DATA_BITS] != crc_acc) begin
                clear_search();
                res.status = ST_CRC_ERROR;
              end else begin
                saved_path    = pass_path;
                last_disc     = pass_zero;
                last_dev_flag = (pass_zero == '0);
                res.status      = ST_FOUND;
                res.rom_id      = pass_path;
                res.last_device = last_dev_flag;
              end
            end
          end
        end
      end
    endcase
    return res;
  endfunction

  task automatic send_event(input req_t req, input logic pres, input logic idb,
                            input logic cmp, output search_result_t res);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid          <= 1'b1;
    in_ch.req_type       <= req;
    in_ch.presence_seen  <= pres;
    in_ch.id_bit         <= idb;
    in_ch.complement_bit <= cmp;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    res = predict_search_step(req, pres, idb, cmp);
    expected_results.push_back(res);
    events_sent++;
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (stall_mode_left == 0) begin
      stall_mode      = $urandom_range(0, 3);
      stall_mode_left = $urandom_range(16, 160);
    end else begin
      stall_mode_left--;
    end
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= 1'($urandom_range(0, 1));
      2: out_ch.ready <= ($urandom_range(0, 7) != 0);
      default: out_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin : result_check
    search_result_t exp;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        $error("result beat with no expectation pending");
        mismatch_count++;
      end else begin
        exp = expected_results.pop_front();
        if (out_ch.status !== exp.status) begin
          $error("status: expected %0d, actual %0d", exp.status, out_ch.status);
          mismatch_count++;
        end
        if (out_ch.direction !== exp.direction) begin
          $error("direction: expected %0d, actual %0d", exp.direction, out_ch.direction);
          mismatch_count++;
        end
        if (out_ch.rom_id !== exp.rom_id) begin
          $error("rom_id: expected %h, actual %h", exp.rom_id, out_ch.rom_id);
          mismatch_count++;
        end
        if (out_ch.last_device !== exp.last_device) begin
          $error("last_device: expected %0d, actual %0d", exp.last_device,
                 out_ch.last_device);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_idle_events();
    search_result_t res;
    send_event(REQ_RESET, 1'b0, 1'b0, 1'b0, res);
    send_event(REQ_FAULT, 1'b1, 1'b1, 1'b1, res);
    send_event(REQ_PAIR, 1'b0, 1'b0, 1'b1, res);
    send_event(REQ_PAIR, 1'b1, 1'b1, 1'b0, res);
    send_event(REQ_BEGIN, 1'b0, 1'b1, 1'b1, res);
  endtask

  task automatic test_pass_control();
    search_result_t res;
    send_event(REQ_BEGIN, 1'b1, 1'b0, 1'b0, res);
    send_event(REQ_PAIR, 1'b0, 1'b1, 1'b0, res);
    send_event(REQ_PAIR, 1'b1, 1'b0, 1'b1, res);
    send_event(REQ_PAIR, 1'b0, 1'b0, 1'b0, res);
    // restart while a pass is running
    send_event(REQ_BEGIN, 1'b1, 1'b1, 1'b0, res);
    send_event(REQ_PAIR, 1'b0, 1'b0, 1'b0, res);
    send_event(REQ_PAIR, 1'b1, 1'b1, 1'b1, res);
    send_event(REQ_PAIR, 1'b0, 1'b0, 1'b0, res);
    send_event(REQ_BEGIN, 1'b1, 1'b0, 1'b1, res);
    send_event(REQ_PAIR, 1'b0, 1'b1, 1'b0, res);
    send_event(REQ_FAULT, 1'b0, 1'b0, 1'b0, res);
    send_event(REQ_BEGIN, 1'b1, 1'b0, 1'b0, res);
    send_event(REQ_PAIR, 1'b1, 1'b0, 1'b1, res);
    send_event(REQ_RESET, 1'b1, 1'b1, 1'b1, res);
    send_event(REQ_PAIR, 1'b1, 1'b1, 1'b1, res);
  endtask

  task automatic run_search_pass();
    search_result_t res;
    logic [MAX_DEVICES-1:0] alive;
    logic idb;
    logic cmp;
    req_t abort_req;
    int flaw;
    int flaw_at;
    // flaw 0: no presence, 1: pass aborted, 2: garbled pair, otherwise clean
    flaw    = $urandom_range(0, 11);
    flaw_at = $urandom_range(0, ROM_BITS - 1);
    send_event(REQ_BEGIN, flaw != 0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               res);
    if (res.status != ST_ACCEPTED) return;
    alive = '1;
    for (int k = 0; k < ROM_BITS; k++) begin
      if (flaw == 1 && k == flaw_at) begin
        case ($urandom_range(0, 2))
          0: abort_req = REQ_RESET;
          1: abort_req = REQ_FAULT;
          default: abort_req = REQ_BEGIN;
        endcase
        send_event(abort_req, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), res);
        return;
      end
      idb = 1'b1;
      cmp = 1'b1;
      for (int d = 0; d < n_devices; d++) begin
        if (alive[d]) begin
          idb = idb & bus_devices[d][k];
          cmp = cmp & ~bus_devices[d][k];
        end
      end
      if (flaw == 2 && k == flaw_at) {idb, cmp} = 2'($urandom_range(0, 3));
      send_event(REQ_PAIR, 1'($urandom_range(0, 1)), idb, cmp, res);
      if (res.status != ST_DIRECTION) return;
      for (int d = 0; d < n_devices; d++)
        if (bus_devices[d][k] != res.direction) alive[d] = 1'b0;
    end
  endtask

  task automatic test_device_searches(input int target);
    search_result_t res;
    rom_t base;
    rom_t rom;
    logic [7:0] crc;
    int bad_dev;
    while (events_sent < target) begin
      n_devices = $urandom_range(1, MAX_DEVICES);
      bad_dev   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, n_devices - 1) : -1;
      base      = {$urandom, $urandom};
      for (int d = 0; d < n_devices; d++) begin
        rom = base;
        if (d > 0 && $urandom_range(0, 2) == 0) rom = {$urandom, $urandom};
        else if (d > 0) repeat ($urandom_range(1, 3)) rom[$urandom_range(0, 55)] ^= 1'b1;
        crc = '0;
        for (int k = 0; k < CRC_DATA_BITS; k++) crc = crc_step(crc, rom[k]);
        rom[ROM_BITS-1:CRC_DATA_BITS] = crc;
        if (d == bad_dev) rom[CRC_DATA_BITS + $urandom_range(0, 7)] ^= 1'b1;
        bus_devices[d] = rom;
      end
      send_event(REQ_RESET, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), res);
      repeat (n_devices + 2) run_search_pass();
    end
  endtask

  task automatic test_random_events(input int count);
    search_result_t res;
    req_t req;
    int stop_at;
    int pick;
    stop_at = events_sent + count;
    while (events_sent < stop_at) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) req = REQ_RESET;
      else if (pick == 1) req = REQ_FAULT;
      else if (pick < 4) req = REQ_BEGIN;
      else req = REQ_PAIR;
      send_event(req, $urandom_range(0, 4) != 0, 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), res);
    end
  endtask

  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.req_type       = REQ_RESET;
    in_ch.presence_seen  = 1'b0;
    in_ch.id_bit         = 1'b0;
    in_ch.complement_bit = 1'b0;
    events_sent          = 0;
    burst_left           = 0;
    n_devices            = 0;
    saved_path           = '0;
    last_disc            = '0;
    last_dev_flag        = 1'b0;
    pass_path            = '0;
    pass_zero            = '0;
    bit_pos              = '0;
    in_pass              = 1'b0;
    crc_acc              = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_events();
    test_pass_control();
    test_device_searches(1450);
    test_random_events(250);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_CYCLES * CLK_PERIOD);
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/owrs_pkg.sv
sv/owrs_in_if.sv
sv/owrs_out_if.sv
sv/one_wire_rom_search_engine.sv
bench/tb_one_wire_rom_search_engine.sv
